// ===== hw/rtl/wfpg_pkg.sv =====
// Shared types, register indexes and color constants for the window frame pixel generator.
package wfpg_pkg;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int POS_W   = 13;
    localparam int SIZE_W  = 13;
    localparam int COLOR_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Internal arithmetic width, wide enough for every offset and bound.
    localparam int CALC_W = 16;

    // Default screen limit.
    localparam int MAX_SCREEN_DIM = 4096;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TITLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCUSED = 3'd6;

    // Register reset values.
    localparam logic [SIZE_W-1:0]  RST_WIDTH  = 13'd256;
    localparam logic [SIZE_W-1:0]  RST_HEIGHT = 13'd256;
    localparam logic [COLOR_W-1:0] RST_FRAME  = 32'hFF4488FF;
    localparam logic [COLOR_W-1:0] RST_TITLE  = 32'hFF222233;

    // Fixed colors.
    localparam logic [COLOR_W-1:0] GREY_FRAME  = 32'hFF555555;
    localparam logic [COLOR_W-1:0] CROSS_WHITE = 32'hFFFFFFFF;
    localparam logic [COLOR_W-1:0] BOX_RED     = 32'hFFFF3333;

    // Frame geometry.
    localparam logic signed [CALC_W-1:0] TITLE_ROWS = 16'sd24;
    localparam logic signed [CALC_W-1:0] FRAME_PIX  = 16'sd2;
    localparam logic signed [CALC_W-1:0] BOX_FAR    = 16'sd20;
    localparam logic signed [CALC_W-1:0] BOX_NEAR   = 16'sd5;
    localparam logic signed [CALC_W-1:0] BOX_SPAN   = 16'sd15;

    // Window configuration as seen by the shading logic.
    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
        logic [COLOR_W-1:0]      frame;
        logic [COLOR_W-1:0]      title;
        logic                    focused;
    } t_win_cfg;

endpackage

// ===== hw/rtl/wfpg_shade.sv =====
// Per-pixel coverage test and frame, title bar and close box shading.
module wfpg_shade #(
    parameter int MAX_DIM = wfpg_pkg::MAX_SCREEN_DIM
) (
    input  wfpg_pkg::t_win_cfg                i_cfg,
    input  logic [wfpg_pkg::COORD_W-1:0]      i_pixel_x,
    input  logic [wfpg_pkg::COORD_W-1:0]      i_pixel_y,
    input  logic [wfpg_pkg::COLOR_W-1:0]      i_content_pixel,
    output logic [wfpg_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic                              o_covered
);

    localparam int CW = wfpg_pkg::CALC_W;
    localparam logic [CW-1:0] SCREEN_LIM = CW'(MAX_DIM);

    logic [CW-1:0]        px_u;
    logic [CW-1:0]        py_u;
    logic signed [CW-1:0] left_s;
    logic signed [CW-1:0] top_s;
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] h_s;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] d;
    logic signed [CW-1:0] e;
    logic [wfpg_pkg::COLOR_W-1:0] border;
    logic in_window;
    logic in_bars;
    logic in_title_bg;
    logic in_box;
    logic on_cross;
    logic in_side;

    // Window offsets of the pixel, all in signed arithmetic without wrap.
    always_comb begin
        px_u   = {{(CW - wfpg_pkg::COORD_W){1'b0}}, i_pixel_x};
        py_u   = {{(CW - wfpg_pkg::COORD_W){1'b0}}, i_pixel_y};
        left_s = {{(CW - wfpg_pkg::POS_W){i_cfg.left[wfpg_pkg::POS_W-1]}}, i_cfg.left};
        top_s  = {{(CW - wfpg_pkg::POS_W){i_cfg.top[wfpg_pkg::POS_W-1]}}, i_cfg.top};
        w_s    = {{(CW - wfpg_pkg::SIZE_W){1'b0}}, i_cfg.width};
        h_s    = {{(CW - wfpg_pkg::SIZE_W){1'b0}}, i_cfg.height};
        sx     = $signed(px_u) - left_s;
        sy     = $signed(py_u) - top_s;
        d      = sx - (w_s - wfpg_pkg::BOX_FAR);
        e      = sy - wfpg_pkg::BOX_NEAR;
    end

    // Region decode.
    always_comb begin
        in_window = (px_u < SCREEN_LIM) && (py_u < SCREEN_LIM) &&
                    (sx >= 0) && (sx < w_s) && (sy >= 0) && (sy < h_s);
        in_bars = (sy < wfpg_pkg::TITLE_ROWS) || (sy >= h_s - wfpg_pkg::FRAME_PIX);
        in_title_bg = (sy >= wfpg_pkg::FRAME_PIX) && (sy < wfpg_pkg::TITLE_ROWS) &&
                      (sx >= wfpg_pkg::FRAME_PIX) && (sx < w_s - wfpg_pkg::FRAME_PIX);
        in_box = (sx > w_s - wfpg_pkg::BOX_FAR) && (sx < w_s - wfpg_pkg::BOX_NEAR) &&
                 (sy > wfpg_pkg::BOX_NEAR) && (sy < wfpg_pkg::BOX_FAR);
        on_cross = (d == e) || (d == wfpg_pkg::BOX_SPAN - e);
        in_side = (sx < wfpg_pkg::FRAME_PIX) || (sx >= w_s - wfpg_pkg::FRAME_PIX);
        border = i_cfg.focused ? i_cfg.frame : wfpg_pkg::GREY_FRAME;
    end

    // Color selection.
    always_comb begin
        o_covered = in_window;
        if (!in_window) begin
            o_pixel_color = '0;
        end else if (in_bars) begin
            if (in_title_bg && in_box) begin
                o_pixel_color = on_cross ? wfpg_pkg::CROSS_WHITE : wfpg_pkg::BOX_RED;
            end else if (in_title_bg) begin
                o_pixel_color = i_cfg.title;
            end else begin
                o_pixel_color = border;
            end
        end else if (in_side) begin
            o_pixel_color = border;
        end else begin
            o_pixel_color = i_content_pixel;
        end
    end

endmodule

// ===== hw/rtl/window_frame_pixel_generator.sv =====
// Top level of the window frame pixel generator: registers, pipeline and handshakes.
//
//   Channel   Direction  Handshake            Payload
//   pixel in  input      i_valid / o_ready    i_pixel_x, i_pixel_y, i_content_pixel
//   pixel out output     o_valid / i_ready    o_pixel_color, o_covered
//   config    input      i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One item per clock sustained while the output is not stalled; an accepted item passes
// the input register, then the shading logic into the result register that drives the output.
// Reset clears both pipeline valids and loads the register defaults.
// A stall at the output holds the result register; the input register keeps
// accepting while the result register is free or being drained in the same cycle.
module window_frame_pixel_generator #(
    parameter int MAX_SCREEN_DIM = wfpg_pkg::MAX_SCREEN_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [wfpg_pkg::COORD_W-1:0]        i_pixel_x,
    input  logic [wfpg_pkg::COORD_W-1:0]        i_pixel_y,
    input  logic [wfpg_pkg::COLOR_W-1:0]        i_content_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [wfpg_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic                                o_covered,
    input  logic                                i_cfg_wr_en,
    input  logic [wfpg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wfpg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    wfpg_pkg::t_win_cfg r_cfg;

    logic                          r_s1_valid;
    logic [wfpg_pkg::COORD_W-1:0]  r_s1_x;
    logic [wfpg_pkg::COORD_W-1:0]  r_s1_y;
    logic [wfpg_pkg::COLOR_W-1:0]  r_s1_content;

    logic                          r_out_valid;
    logic [wfpg_pkg::COLOR_W-1:0]  r_out_color;
    logic                          r_out_covered;

    logic [wfpg_pkg::COLOR_W-1:0]  n_out_color;
    logic                          n_out_covered;
    logic                          s1_advance;
    logic                          in_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left    <= '0;
            r_cfg.top     <= '0;
            r_cfg.width   <= wfpg_pkg::RST_WIDTH;
            r_cfg.height  <= wfpg_pkg::RST_HEIGHT;
            r_cfg.frame   <= wfpg_pkg::RST_FRAME;
            r_cfg.title   <= wfpg_pkg::RST_TITLE;
            r_cfg.focused <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wfpg_pkg::REG_LEFT:    r_cfg.left    <= $signed(i_cfg_data[wfpg_pkg::POS_W-1:0]);
                wfpg_pkg::REG_TOP:     r_cfg.top     <= $signed(i_cfg_data[wfpg_pkg::POS_W-1:0]);
                wfpg_pkg::REG_WIDTH:   r_cfg.width   <= i_cfg_data[wfpg_pkg::SIZE_W-1:0];
                wfpg_pkg::REG_HEIGHT:  r_cfg.height  <= i_cfg_data[wfpg_pkg::SIZE_W-1:0];
                wfpg_pkg::REG_FRAME:   r_cfg.frame   <= i_cfg_data[wfpg_pkg::COLOR_W-1:0];
                wfpg_pkg::REG_TITLE:   r_cfg.title   <= i_cfg_data[wfpg_pkg::COLOR_W-1:0];
                wfpg_pkg::REG_FOCUSED: r_cfg.focused <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control.
    assign s1_advance = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || s1_advance;
    assign in_take    = i_valid && o_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_x       <= i_pixel_x;
            r_s1_y       <= i_pixel_y;
            r_s1_content <= i_content_pixel;
        end
    end

    // Shading logic between the two registers.
    wfpg_shade #(
        .MAX_DIM(MAX_SCREEN_DIM)
    ) u_shade (
        .i_cfg           (r_cfg),
        .i_pixel_x       (r_s1_x),
        .i_pixel_y       (r_s1_y),
        .i_content_pixel (r_s1_content),
        .o_pixel_color   (n_out_color),
        .o_covered       (n_out_covered)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_color   <= n_out_color;
            r_out_covered <= n_out_covered;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_out_color;
    assign o_covered     = r_out_covered;

endmodule

// ===== hw/rtl/wfpg_checker.sv =====
// Port-level checks for the window frame pixel generator, bound to the top level.
module wfpg_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [wfpg_pkg::COLOR_W-1:0]        o_pixel_color,
    input logic                                o_covered
);

    // A pixel outside the window always comes out black.
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_covered |-> o_pixel_color == '0)
        else $error("uncovered item with nonzero color");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_color) && $stable(o_covered))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A draining output never blocks the input.
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input blocked while output drains");

    // An item taken while the output is empty fills it via both registers.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> ##1 o_valid)
        else $error("accepted item did not reach the output");

endmodule

bind window_frame_pixel_generator wfpg_checker u_wfpg_checker (.*);

// ===== tb/window_frame_pixel_generator_test.sv =====
// Self-checking testbench for the window frame pixel generator.
`timescale 1ns / 100ps

module window_frame_pixel_generator_test;

    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 18;
    localparam int PHASE_PIXELS   = 100;
    localparam int MAX_REPORTS    = 30;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [wfpg_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // One expected pixel, with its coordinates kept for messages.
    typedef struct {
        logic [wfpg_pkg::COORD_W-1:0] px;
        logic [wfpg_pkg::COORD_W-1:0] py;
        logic [wfpg_pkg::COLOR_W-1:0] color;
        logic                         covered;
    } t_pixel_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [wfpg_pkg::COORD_W-1:0]    i_pixel_x = '0;
    logic [wfpg_pkg::COORD_W-1:0]    i_pixel_y = '0;
    logic [wfpg_pkg::COLOR_W-1:0]    i_content_pixel = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [wfpg_pkg::COLOR_W-1:0]    o_pixel_color;
    logic                            o_covered;
    logic                            i_cfg_wr_en = 1'b0;
    logic [wfpg_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [wfpg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the window registers and the queue of pending pixels.
    wfpg_pkg::t_win_cfg win;
    t_pixel_result      expected_pixels[$];

    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int errors      = 0;
    int items_sent  = 0;
    int results_checked = 0;
    int settings_used   = 1;

    window_frame_pixel_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_content_pixel (i_content_pixel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_color   (o_pixel_color),
        .o_covered       (o_covered),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Color the window puts on one screen pixel under the shadow registers.
    function automatic t_pixel_result shade_pixel(logic [wfpg_pkg::COORD_W-1:0] x,
                                                  logic [wfpg_pkg::COORD_W-1:0] y,
                                                  logic [wfpg_pkg::COLOR_W-1:0] content);
        t_pixel_result r;
        int sx, sy, w, h, d, e;
        logic [wfpg_pkg::COLOR_W-1:0] border;
        r.px = x;
        r.py = y;
        r.color = '0;
        r.covered = 1'b0;
        w = int'(win.width);
        h = int'(win.height);
        sx = int'(x) - int'($signed(win.left));
        sy = int'(y) - int'($signed(win.top));
        if (int'(x) >= wfpg_pkg::MAX_SCREEN_DIM || int'(y) >= wfpg_pkg::MAX_SCREEN_DIM ||
            sx < 0 || sx >= w || sy < 0 || sy >= h) begin
            return r;
        end
        border = win.focused ? win.frame : wfpg_pkg::GREY_FRAME;
        r.covered = 1'b1;
        if (sy < wfpg_pkg::TITLE_ROWS || sy >= h - wfpg_pkg::FRAME_PIX) begin
            r.color = border;
            // Title bar interior, with the close box near its right end.
            if (sy >= wfpg_pkg::FRAME_PIX && sy < wfpg_pkg::TITLE_ROWS &&
                sx >= wfpg_pkg::FRAME_PIX && sx < w - wfpg_pkg::FRAME_PIX) begin
                r.color = win.title;
                if (sx > w - wfpg_pkg::BOX_FAR && sx < w - wfpg_pkg::BOX_NEAR &&
                    sy > wfpg_pkg::BOX_NEAR && sy < wfpg_pkg::BOX_FAR) begin
                    d = sx - (w - wfpg_pkg::BOX_FAR);
                    e = sy - wfpg_pkg::BOX_NEAR;
                    r.color = (d == e || d == wfpg_pkg::BOX_SPAN - e) ?
                              wfpg_pkg::CROSS_WHITE : wfpg_pkg::BOX_RED;
                end
            end
        end else if (sx < wfpg_pkg::FRAME_PIX || sx >= w - wfpg_pkg::FRAME_PIX) begin
            r.color = border;
        end else begin
            r.color = content;
        end
        return r;
    endfunction

    function automatic wfpg_pkg::t_win_cfg make_window(int l, int t, int w, int h,
                                                       logic [wfpg_pkg::COLOR_W-1:0] f,
                                                       logic [wfpg_pkg::COLOR_W-1:0] ti,
                                                       bit foc);
        wfpg_pkg::t_win_cfg c;
        c.left = l[wfpg_pkg::POS_W-1:0];
        c.top = t[wfpg_pkg::POS_W-1:0];
        c.width = w[wfpg_pkg::SIZE_W-1:0];
        c.height = h[wfpg_pkg::SIZE_W-1:0];
        c.frame = f;
        c.title = ti;
        c.focused = foc;
        return c;
    endfunction

    // Mostly ordinary windows near the visible area, with some tiny, huge and wild ones.
    function automatic wfpg_pkg::t_win_cfg random_window();
        int kind, w, h, l, t;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            w = $urandom_range(32, 600);
            h = $urandom_range(32, 600);
        end else if (kind == 6) begin
            w = $urandom_range(0, 31);
            h = $urandom_range(0, 40);
        end else if (kind == 7) begin
            w = $urandom_range(4000, 8191);
            h = $urandom_range(4000, 8191);
        end else begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
        end
        if (kind == 9) begin
            l = int'($urandom_range(0, 8191)) - 4096;
            t = int'($urandom_range(0, 8191)) - 4096;
        end else begin
            l = int'($urandom_range(0, 800)) - 200;
            t = int'($urandom_range(0, 800)) - 200;
        end
        return make_window(l, t, w, h, $urandom(), $urandom(), $urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Sends one pixel item and records what the block should return for it.
    task automatic send_pixel(input logic [wfpg_pkg::COORD_W-1:0] x,
                              input logic [wfpg_pkg::COORD_W-1:0] y,
                              input logic [wfpg_pkg::COLOR_W-1:0] content);
        int gap;
        t_pixel_result want;
        gap = (src_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        i_content_pixel <= content;
        want = shade_pixel(x, y, content);
        do @(posedge i_clk); while (o_ready !== 1'b1);
        expected_pixels.push_back(want);
        items_sent++;
    endtask

    // Holds the sender until every pending pixel has come back and the pipe is empty.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [wfpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wfpg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Writes every register once; unused upper data bits carry noise.
    task automatic apply_window(input wfpg_pkg::t_win_cfg cfg, input bit poke_spare);
        logic [wfpg_pkg::CFG_DATA_W-1:0] pad;
        wait_drained();
        pad = $urandom();
        cfg_write(wfpg_pkg::REG_LEFT, {pad[31:13], cfg.left});
        cfg_write(wfpg_pkg::REG_TOP, {pad[30:12], cfg.top});
        cfg_write(wfpg_pkg::REG_WIDTH, {pad[29:11], cfg.width});
        cfg_write(wfpg_pkg::REG_HEIGHT, {pad[28:10], cfg.height});
        cfg_write(wfpg_pkg::REG_FRAME, cfg.frame);
        cfg_write(wfpg_pkg::REG_TITLE, cfg.title);
        cfg_write(wfpg_pkg::REG_FOCUSED, {pad[31:1], cfg.focused});
        if (poke_spare) begin
            cfg_write(REG_SPARE, $urandom());
        end
        i_cfg_wr_en <= 1'b0;
        win = cfg;
        settings_used++;
    endtask

    // Reset window: corners, title bar, close box edges and strokes, borders, content.
    task automatic test_reset_window();
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'd256, 12'd0, 32'h5A5A_A5A5);
        send_pixel(12'd100, 12'd256, 32'h5A5A_A5A5);
        send_pixel(12'd2, 12'd2, 32'h5A5A_A5A5);
        send_pixel(12'd254, 12'd10, 32'h5A5A_A5A5);
        send_pixel(12'd237, 12'd6, 32'h5A5A_A5A5);
        send_pixel(12'd238, 12'd6, 32'h5A5A_A5A5);
        send_pixel(12'd250, 12'd6, 32'h5A5A_A5A5);
        send_pixel(12'd236, 12'd10, 32'h5A5A_A5A5);
        send_pixel(12'd240, 12'd20, 32'h5A5A_A5A5);
        send_pixel(12'd2, 12'd24, 32'hFFFF_FFFF);
        send_pixel(12'd1, 12'd100, 32'hA5A5_5A5A);
        send_pixel(12'd100, 12'd254, 32'hA5A5_5A5A);
    endtask

    // Windows at the register extremes, empty, undersized and partly off screen.
    task automatic test_odd_windows();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        apply_window(make_window(-4096, -4096, 8191, 8191, 32'hFFFF_FFFF, 32'h0, 1'b1), 1'b1);
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_pixel(12'd4094, 12'd4094, 32'h1234_5678);
        apply_window(make_window(4095, 4095, 32, 32, 32'h0, 32'hFFFF_FFFF, 1'b1), 1'b0);
        send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_pixel(12'd4094, 12'd4095, 32'hFFFF_FFFF);
        apply_window(make_window(10, 10, 0, 0, 32'h0, 32'h0, 1'b0), 1'b0);
        send_pixel(12'd10, 12'd10, 32'h8765_4321);
        apply_window(make_window(0, 0, 5, 3, 32'hFF00_FF00, 32'hFF11_2233, 1'b1), 1'b0);
        send_pixel(12'd2, 12'd2, 32'h8765_4321);
        send_pixel(12'd4, 12'd0, 32'h8765_4321);
        apply_window(make_window(-10, -5, 40, 4096, 32'hFF00_00FF, 32'hFFAB_CDEF, 1'b0), 1'b0);
        send_pixel(12'd0, 12'd0, 32'h8765_4321);
        send_pixel(12'd0, 12'd4090, 32'h8765_4321);
        send_pixel(12'd29, 12'd5, 32'h8765_4321);
    endtask

    // Random windows, each fed pixels over and just around its area, some near the close box, some anywhere.
    task automatic test_random_windows();
        int sel, w, h, ox, oy, x, y;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_window(random_window(), phase % 5 == 0);
            sel = $urandom_range(0, 3);
            src_gaps = sel[0];
            sink_stalls = sel[1];
            w = int'(win.width);
            h = int'(win.height);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                if (phase == RANDOM_PHASES / 2 && n == PHASE_PIXELS / 2) begin
                    wait_drained();
                end
                sel = $urandom_range(0, 99);
                if (sel < 20) begin
                    ox = int'($urandom_range(0, 24)) + w - 23;
                    oy = int'($urandom_range(0, 25)) - 1;
                end else begin
                    ox = int'($urandom_range(0, w + 7)) - 4;
                    oy = int'($urandom_range(0, h + 7)) - 4;
                end
                x = int'($signed(win.left)) + ox;
                y = int'($signed(win.top)) + oy;
                if (sel < 8 || x < 0 || x >= wfpg_pkg::MAX_SCREEN_DIM) begin
                    x = $urandom_range(0, wfpg_pkg::MAX_SCREEN_DIM - 1);
                end
                if (sel < 8 || y < 0 || y >= wfpg_pkg::MAX_SCREEN_DIM) begin
                    y = $urandom_range(0, wfpg_pkg::MAX_SCREEN_DIM - 1);
                end
                send_pixel(x[wfpg_pkg::COORD_W-1:0], y[wfpg_pkg::COORD_W-1:0], $urandom());
            end
        end
    endtask

    // Receiver with random stalls.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left <= idle_length();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compares each returned pixel with the oldest pending one.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result item with no pixel pending");
            end else begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (o_pixel_color !== want.color) begin
                    report_mismatch($sformatf("pixel (%0d,%0d) color %h, want %h",
                                              want.px, want.py, o_pixel_color, want.color));
                end
                if (o_covered !== want.covered) begin
                    report_mismatch($sformatf("pixel (%0d,%0d) covered %b, want %b",
                                              want.px, want.py, o_covered, want.covered));
                end
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_valid && o_ready === 1'b1) ||
            (o_valid === 1'b1 && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        win = make_window(0, 0, int'(wfpg_pkg::RST_WIDTH), int'(wfpg_pkg::RST_HEIGHT),
                          wfpg_pkg::RST_FRAME, wfpg_pkg::RST_TITLE, 1'b0);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_window();
        test_odd_windows();
        test_random_windows();
        wait_drained();
        $display("Checked %0d of %0d pixels over %0d window settings,", results_checked,
                 items_sent, settings_used);
        $display("from empty and undersized windows to 8191-pixel ones at both screen limits.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
